/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the edit distance engine checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define EDC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define EDC_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/edc_pkg.sv */
// ----------------------------------------------------------------------------
// Edit distance engine package
// Types and fixed constants shared by the engine, its channels and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package edc_pkg;

  localparam int SYM_W  = 8;
  localparam int DIST_W = 8;

  typedef logic [SYM_W-1:0]  sym_t;
  typedef logic [DIST_W-1:0] dist_t;

  // Largest distance the result word can carry; longer distances saturate.
  localparam dist_t DIST_MAX = dist_t'(255);

endpackage

`default_nettype wire

/* rtl/core/edc_if.sv */
// ----------------------------------------------------------------------------
// Edit distance engine channels
// Valid/ready channels for symbol words in and distance words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface edc_in_if import edc_pkg::*;;
  logic valid;
  logic ready;
  sym_t sym_a;
  sym_t sym_b;
  logic last;

  modport source (output valid, output sym_a, output sym_b, output last, input ready);
  modport sink   (input valid, input sym_a, input sym_b, input last, output ready);
endinterface

interface edc_out_if import edc_pkg::*;;
  logic  valid;
  logic  ready;
  dist_t distance;
  logic  overflow;

  modport source (output valid, output distance, output overflow, input ready);
  modport sink   (input valid, input distance, input overflow, output ready);
endinterface

`default_nettype wire

/* rtl/core/edc_cell.sv */
// ----------------------------------------------------------------------------
// Edit distance cell unit
// Shared add and minimum unit that evaluates one cost matrix cell.
// ----------------------------------------------------------------------------
`default_nettype none

module edc_cell #(
  parameter int CW = 8
) (
  input  logic [CW-1:0] up,
  input  logic [CW-1:0] left,
  input  logic [CW-1:0] diag,
  input  logic          match,
  output logic [CW-1:0] cell_cost
);

  logic [CW:0] del_c;
  logic [CW:0] ins_c;
  logic [CW:0] sub_c;
  logic [CW:0] min_ab;
  logic [CW:0] min_all;

  always_comb begin
    del_c   = {1'b0, up} + (CW+1)'(1);
    ins_c   = {1'b0, left} + (CW+1)'(1);
    sub_c   = {1'b0, diag} + (CW+1)'(!match);
    min_ab  = (ins_c < del_c) ? ins_c : del_c;
    min_all = (sub_c < min_ab) ? sub_c : min_ab;
  end

  // A cell never exceeds the string length, so the top bit is always clear.
  assign cell_cost = min_all[CW-1:0];

endmodule

`default_nettype wire

/* rtl/core/edit_distance_engine_core.sv */
// ----------------------------------------------------------------------------
// Edit distance engine core
// Loads two equal-length symbol strings and returns their Levenshtein distance.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Words carried                 Accepted when
//   in_ch    in   sym_a, sym_b, last            in_ch.valid && in_ch.ready
//   out_ch   out  distance, overflow            out_ch.valid && out_ch.ready
//
// During loading a new word is taken every cycle in which in_ch.valid is high.
// After the word flagged last, a string length n gives n rows, each opened in
// S_ROW and stepped cell by cell, set by the single cell unit and the one-port
// cost row memory: each cell reads the memories in S_RD, then computes and
// writes back in S_CALC. The result word then waits in its register until taken.
// Reset (rst_n low, synchronous) clears the sequencer, load count and overflow
// flag; the memories hold no reset value and need no clearing pass.
// in_ch.ready is low from the last word until the result word has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module edit_distance_engine_core import edc_pkg::*; #(
  parameter int MAX_LEN = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  edc_in_if.sink     in_ch,
  edc_out_if.source  out_ch
);

  // Count width holds 0..MAX_LEN; store index width covers MAX_LEN entries.
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  // Wide enough to compare a cost against the saturation limit.
  localparam int XW = (CW > DIST_W) ? CW : DIST_W + 1;

  // Sequencer states.
  localparam logic [2:0] S_LOAD = 3'd0;  // taking symbol words
  localparam logic [2:0] S_ROW  = 3'd1;  // start of a matrix row, fetch sym_a
  localparam logic [2:0] S_RD   = 3'd2;  // fetch cost row entry and sym_b
  localparam logic [2:0] S_CALC = 3'd3;  // evaluate one cell and write it back
  localparam logic [2:0] S_OUT  = 3'd4;  // result word waiting to be taken

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic [CW-1:0] diag_r, diag_nxt;
  dist_t         dist_r, dist_nxt;

  // Symbol stores and one row of the cost matrix, each with a registered read.
  sym_t          store_a_mem [MAX_LEN];
  sym_t          store_b_mem [MAX_LEN];
  logic [CW-1:0] cost_mem    [MAX_LEN+1];
  sym_t          a_rd_r;
  sym_t          b_rd_r;
  logic [CW-1:0] up_rd_r;

  logic          in_acc;
  logic          out_acc;
  logic          store_wr;
  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] i_m1;
  logic [CW-1:0] j_m1;
  logic [CW-1:0] up_val;
  logic [CW-1:0] cell_val;
  logic [XW-1:0] cell_x;
  dist_t         dist_sat;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  // A word that arrives with the store full is dropped and flags overflow.
  assign store_wr = in_acc && (cnt_r < CW'(MAX_LEN));
  assign cnt_inc  = store_wr ? cnt_r + CW'(1) : cnt_r;

  assign i_m1 = i_r - CW'(1);
  assign j_m1 = j_r - CW'(1);

  // Row zero of the matrix is simply j, so the first row never uses the value read
  // from the cost memory and the memory needs no initialization sweep.
  assign up_val = (i_r == CW'(1)) ? j_r : up_rd_r;

  edc_cell #(
    .CW (CW)
  ) u_cell (
    .up        (up_val),
    .left      (left_r),
    .diag      (diag_r),
    .match     (a_rd_r == b_rd_r),
    .cell_cost (cell_val)
  );

  // Distances beyond the result width saturate.
  assign cell_x   = XW'(cell_val);
  assign dist_sat = (cell_x > XW'(DIST_MAX)) ? DIST_MAX : cell_x[DIST_W-1:0];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    len_nxt   = len_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    left_nxt  = left_r;
    diag_nxt  = diag_r;
    dist_nxt  = dist_r;

    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          cnt_nxt = cnt_inc;
          ovf_nxt = ovf_r || !store_wr;
          if (in_ch.last) begin
            len_nxt = cnt_inc;
            i_nxt   = CW'(1);
            if (cnt_inc == '0) begin
              // Two empty strings have distance zero.
              dist_nxt  = '0;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_ROW;
            end
          end
        end
      end
      S_ROW: begin
        // Column zero of row i holds i; the diagonal starts at i - 1.
        j_nxt     = CW'(1);
        left_nxt  = i_r;
        diag_nxt  = i_m1;
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_CALC;
      end
      S_CALC: begin
        left_nxt = cell_val;
        diag_nxt = up_val;
        if (j_r == len_r) begin
          if (i_r == len_r) begin
            dist_nxt  = dist_sat;
            state_nxt = S_OUT;
          end else begin
            i_nxt     = i_r + CW'(1);
            state_nxt = S_ROW;
          end
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_RD;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    left_r <= left_nxt;
    diag_r <= diag_nxt;
    dist_r <= dist_nxt;
  end

  // First string: written during the load, read once at the start of each row.
  always_ff @(posedge clk) begin
    if (store_wr) begin
      store_a_mem[cnt_r[AW-1:0]] <= in_ch.sym_a;
    end
    if (state_r == S_ROW) begin
      a_rd_r <= store_a_mem[i_m1[AW-1:0]];
    end
  end

  // Second string: written during the load, read once per cell.
  always_ff @(posedge clk) begin
    if (store_wr) begin
      store_b_mem[cnt_r[AW-1:0]] <= in_ch.sym_b;
    end
    if (state_r == S_RD) begin
      b_rd_r <= store_b_mem[j_m1[AW-1:0]];
    end
  end

  // Cost row: entry j is read for the cell above in S_RD, then overwritten with
  // the new cell in the following S_CALC cycle.
  always_ff @(posedge clk) begin
    if (state_r == S_CALC) begin
      cost_mem[j_r] <= cell_val;
    end
    if (state_r == S_RD) begin
      up_rd_r <= cost_mem[j_r];
    end
  end

  assign in_ch.ready     = (state_r == S_LOAD);
  assign out_ch.valid    = (state_r == S_OUT);
  assign out_ch.distance = dist_r;
  assign out_ch.overflow = ovf_r;

endmodule

`default_nettype wire

/* rtl/core/edc_checker.sv */
// ----------------------------------------------------------------------------
// Edit distance engine checker
// Port-level assertions on load and result sequencing of the core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module edc_checker import edc_pkg::*; (
  input wire logic  clk,
  input wire logic  rst_n,
  input wire logic  in_valid,
  input wire logic  in_ready,
  input wire logic  in_last,
  input wire logic  out_valid,
  input wire logic  out_ready,
  input wire dist_t distance,
  input wire logic  overflow
);

  // A stalled result word keeps its contents.
  `EDC_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(overflow), "result word changed while stalled")

  // The block never takes symbols while a result word is pending.
  `EDC_ASSERT(a_no_overlap, clk, rst_n, !(in_ready && out_valid), "input ready while result pending")

  // The last word of a string ends the load at once.
  `EDC_ASSERT(a_last_stops, clk, rst_n, in_valid && in_ready && in_last |=> !in_ready, "input still ready after last word")

  // Taking the result word reopens the load.
  `EDC_ASSERT(a_reopen, clk, rst_n, out_valid && out_ready |=> in_ready && !out_valid, "load not reopened after result")

  // Reset leaves the block ready to load with no result pending.
  `EDC_ASSERT_RST(a_reset, clk, !rst_n |=> in_ready && !out_valid, "wrong state after reset")

endmodule

bind edit_distance_engine_core edc_checker u_edc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .distance  (out_ch.distance),
  .overflow  (out_ch.overflow)
);

`default_nettype wire

/* dv/edit_distance_engine_checker.sv */
// ----------------------------------------------------------------------------
// Edit distance engine checker
// Watches both channels, predicts each distance word and compares it.
// ----------------------------------------------------------------------------
module edit_distance_engine_checker import edc_pkg::*; #(
  parameter int MAX_LEN = 128
) (
  input  logic clk,
  input  logic rst_n,
  edc_in_if    in_ch,
  edc_out_if   out_ch,
  output int   fail_count,
  output int   pending_words,
  output int   results_taken
);

  typedef struct packed {
    dist_t distance;
    logic  overflow;
  } dist_word_t;

  sym_t       string_a[MAX_LEN];
  sym_t       string_b[MAX_LEN];
  int         pair_count;
  bit         pair_dropped;
  int         cost_row[MAX_LEN+1];
  dist_word_t expected_distances[$];
  int         mismatches;
  int         taken;

  // Single-row dynamic program over the pairs stored in this load.
  function automatic dist_t levenshtein(input int n);
    int diag;
    int up;
    int sub;
    int best;
    for (int j = 0; j <= n; j++) cost_row[j] = j;
    for (int i = 1; i <= n; i++) begin
      diag = cost_row[0];
      cost_row[0] = i;
      for (int j = 1; j <= n; j++) begin
        up = cost_row[j];
        sub = (string_a[i-1] == string_b[j-1]) ? 0 : 1;
        best = up + 1;
        if (cost_row[j-1] + 1 < best) best = cost_row[j-1] + 1;
        if (diag + sub < best) best = diag + sub;
        cost_row[j] = best;
        diag = up;
      end
    end
    if (cost_row[n] > 255) return DIST_MAX;
    return dist_t'(cost_row[n]);
  endfunction

  always @(posedge clk) begin : monitor
    dist_word_t want;
    if (!rst_n) begin
      pair_count = 0;
      pair_dropped = 1'b0;
    end else begin
      // The result side goes first: a word leaving now can never belong to
      // a load that finishes at this same edge.
      if (out_ch.valid && out_ch.ready) begin
        taken++;
        if (expected_distances.size() == 0) begin
          $error("unexpected result word: distance %0d, overflow %0b",
                 out_ch.distance, out_ch.overflow);
          mismatches++;
        end else begin
          want = expected_distances.pop_front();
          if (out_ch.distance !== want.distance) begin
            $error("distance mismatch: expected %0d, actual %0d",
                   want.distance, out_ch.distance);
            mismatches++;
          end
          if (out_ch.overflow !== want.overflow) begin
            $error("overflow mismatch: expected %0b, actual %0b",
                   want.overflow, out_ch.overflow);
            mismatches++;
          end
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        if (pair_count < MAX_LEN) begin
          string_a[pair_count] = in_ch.sym_a;
          string_b[pair_count] = in_ch.sym_b;
          pair_count++;
        end else begin
          pair_dropped = 1'b1;
        end
        if (in_ch.last) begin
          want.distance = levenshtein(pair_count);
          want.overflow = pair_dropped;
          expected_distances.push_back(want);
          pair_count = 0;
          pair_dropped = 1'b0;
        end
      end
    end
    fail_count    <= mismatches;
    pending_words <= expected_distances.size();
    results_taken <= taken;
  end

endmodule

/* dv/edit_distance_engine_core_tb.sv */
// ----------------------------------------------------------------------------
// Edit distance engine testbench
// Feeds symbol strings of many lengths and shapes under varying flow control
// and lets a side checker compare every distance word with its prediction.
// ----------------------------------------------------------------------------
module edit_distance_engine_core_tb;
  import edc_pkg::*;

  localparam int MAX_LEN     = 128;
  localparam int ITEM_TARGET = 1700;
  // Upper bound on the run length; the watchdog fails the run past it.
  localparam int CYCLE_LIMIT = 1_500_000;
  // The engine is idle once its result word is taken, so a short settle
  // window at the end is enough to catch a stray word.
  localparam int SETTLE_CYCLES = 300;

  logic clk;
  logic rst_n;

  edc_in_if  in_ch ();
  edc_out_if out_ch ();

  int fail_count;
  int pending_words;
  int results_taken;

  int sender_idle_pct;
  int receiver_idle_pct;
  int words_sent;
  int cycle_count;

  // Receiver hold-off bookkeeping, owned by the receiver process.
  int hold_left;
  int holds_done;
  int next_hold_mark;

  edit_distance_engine_core #(.MAX_LEN(MAX_LEN)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  edit_distance_engine_checker #(.MAX_LEN(MAX_LEN)) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending_words (pending_words),
    .results_taken (results_taken)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run watchdog. A missing result word ends up here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offers one symbol word, after a random number of idle cycles, and returns
  // at the edge where the engine takes it. The valid line stays high into the
  // next call, so back-to-back words need no gap.
  task automatic send_word(input sym_t a, input sym_t b, input logic is_last);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sym_a <= a;
    in_ch.sym_b <= b;
    in_ch.last  <= is_last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // Stops offering words until every predicted distance has been taken.
  // The first wait also lets the checker see the word taken at this edge.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  // Builds a string pair of the given length and shape and sends it.
  // Shapes: 0 unrelated full-range symbols, 1 a four-symbol alphabet,
  // 2 copy with scattered substitutions, 3 copy shifted by one place in
  // either direction, 4 identical copy.
  task automatic send_string(input int len, input int shape);
    sym_t str_a[MAX_LEN+8];
    sym_t str_b[MAX_LEN+8];
    bit   shift_left;
    shift_left = $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      str_a[i] = (shape == 1) ? sym_t'($urandom_range(0, 3)) : sym_t'($urandom);
    end
    for (int i = 0; i < len; i++) begin
      case (shape)
        0: str_b[i] = sym_t'($urandom);
        1: str_b[i] = sym_t'($urandom_range(0, 3));
        2: str_b[i] = ($urandom_range(0, 3) == 0) ? sym_t'($urandom) : str_a[i];
        3: begin
          if (shift_left) str_b[i] = (i + 1 < len) ? str_a[i+1] : sym_t'($urandom);
          else            str_b[i] = (i > 0) ? str_a[i-1] : sym_t'($urandom);
        end
        default: str_b[i] = str_a[i];
      endcase
    end
    for (int i = 0; i < len; i++) send_word(str_a[i], str_b[i], i == len - 1);
  endtask

  // Receiver. Twice during the run it refuses result words for a long
  // stretch while the sender keeps offering, so a finished result blocks the
  // engine and the engine in turn holds off the input channel.
  initial begin
    out_ch.ready <= 1'b0;
    hold_left = 0;
    holds_done = 0;
    next_hold_mark = 15;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_done < 2 && results_taken >= next_hold_mark) begin
        hold_left = 600;
        holds_done++;
        next_hold_mark += 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
    end
  end

  // Sender and verdict.
  initial begin
    int len;
    int shape;
    int phase;
    int new_phase;
    int string_idx;
    int long_count;

    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.sym_a <= '0;
    in_ch.sym_b <= '0;
    in_ch.last  <= 1'b0;
    sender_idle_pct   = 37;
    receiver_idle_pct = 54;
    words_sent = 0;
    phase = 0;
    string_idx = 0;
    long_count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings: single-word strings at the symbol extremes, a swap,
    // an insert plus delete, a string that differs everywhere, an exact copy
    // and a shifted copy.
    send_word(8'h00, 8'h00, 1'b1);
    send_word(8'hFF, 8'h00, 1'b1);
    send_word(8'hFF, 8'hFF, 1'b1);
    send_word(8'h41, 8'h42, 1'b0);
    send_word(8'h42, 8'h41, 1'b1);
    send_word(8'h01, 8'h02, 1'b0);
    send_word(8'h02, 8'h03, 1'b0);
    send_word(8'h03, 8'h04, 1'b1);
    repeat (3) send_word(8'hAA, 8'h55, 1'b0);
    send_word(8'hAA, 8'h55, 1'b1);
    send_word(8'h80, 8'h80, 1'b0);
    send_word(8'h7F, 8'h7F, 1'b0);
    send_word(8'h01, 8'h01, 1'b0);
    send_word(8'hFE, 8'hFE, 1'b0);
    send_word(8'h00, 8'h00, 1'b1);
    send_word(8'd10, 8'd20, 1'b0);
    send_word(8'd20, 8'd30, 1'b0);
    send_word(8'd30, 8'd40, 1'b0);
    send_word(8'd40, 8'd50, 1'b1);
    wait_drained();

    // Random strings. Most are short so the quadratic compute time stays
    // low; a handful fill the store exactly or run past it.
    while (words_sent < ITEM_TARGET) begin
      new_phase = (words_sent < 580) ? 0 : (words_sent < 1150) ? 1 : 2;
      if (new_phase != phase) begin
        wait_drained();
        phase = new_phase;
      end
      case (phase)
        0: begin
          sender_idle_pct   = 37;
          receiver_idle_pct = 54;
        end
        1: begin
          sender_idle_pct   = 54;
          receiver_idle_pct = 37;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase

      if (string_idx % 40 == 20) begin
        // First a full store, then one word too many (the last word is
        // dropped), then a few more beyond the end.
        if (long_count == 0)      len = MAX_LEN;
        else if (long_count == 1) len = MAX_LEN + 1;
        else                      len = MAX_LEN + $urandom_range(2, 6);
        long_count++;
      end else begin
        case ($urandom_range(0, 19))
          0:       len = $urandom_range(33, 64);
          1, 2, 3, 4, 5: len = $urandom_range(9, 32);
          default: len = $urandom_range(1, 8);
        endcase
      end
      shape = $urandom_range(0, 4);
      send_string(len, shape);
      string_idx++;

      if ($urandom_range(0, 15) == 0) wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
